// File: src/st_pkg.sv
// ----------------------------------------------------------------------------
// st_pkg: shared types and constants of the source tokenizer
// Token kinds, error codes, counter limits, the token record and the helpers
// that classify characters.
// ----------------------------------------------------------------------------
`default_nettype none

package st_pkg;

  localparam int unsigned PosW = 25;
  localparam int unsigned OfsW = 24;
  localparam int unsigned ValW = 63;

  // Size of the source address space; the byte counter stops at the smaller
  // of this and the line and column limit.
  localparam longint unsigned SourceBytes = 64'd16777216;

  localparam logic [PosW-1:0] LcCap  = 25'(24'hFFFFFF) + 25'd1;
  localparam logic [PosW-1:0] PosCap = (SourceBytes < 64'(LcCap)) ? PosW'(SourceBytes)
                                                                   : LcCap;
  localparam logic [OfsW-1:0] OfsMax = 24'hFFFFFF;
  localparam logic [ValW-1:0] IntMax = {ValW{1'b1}};

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef enum logic [4:0] {
    K_EOF = 5'd0, K_ERROR = 5'd1, K_IDENT = 5'd2, K_FN = 5'd3, K_LINK = 5'd4,
    K_MAIN = 5'd5, K_RETURN = 5'd6, K_INT = 5'd7, K_STRING = 5'd8,
    K_PLUS = 5'd9, K_MINUS = 5'd10, K_POW = 5'd11, K_STAR = 5'd12,
    K_SLASH = 5'd13, K_PERCENT = 5'd14, K_BANG = 5'd15, K_TILDE = 5'd16,
    K_SHL = 5'd17, K_LT = 5'd18, K_SHR = 5'd19, K_GT = 5'd20, K_AMP = 5'd21,
    K_CARET = 5'd22, K_PIPE = 5'd23, K_LPAREN = 5'd24, K_RPAREN = 5'd25,
    K_LBRACE = 5'd26, K_RBRACE = 5'd27, K_SEMI = 5'd28, K_DOT = 5'd29
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE = 3'd0, E_UNSTR = 3'd1, E_UNESC = 3'd2, E_OVF = 3'd3,
    E_NODIG = 3'd4, E_BADDIG = 3'd5, E_BADCHAR = 3'd6
  } err_t;

  typedef enum logic [1:0] {
    B_DEC = 2'd0, B_HEX = 2'd1, B_BIN = 2'd2, B_OCT = 2'd3
  } base_t;

  typedef struct packed {
    kind_t           kind;
    err_t            err;
    logic [PosW-1:0] line;
    logic [PosW-1:0] col;
    logic [PosW-1:0] span;
    logic [OfsW-1:0] toff;
    logic [PosW-1:0] tlen;
    logic [ValW-1:0] value;
    logic            last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_word(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == "_");
  endfunction

  // Single-character operators that never pair up; K_EOF means none.
  function automatic kind_t op_kind(input logic [7:0] b);
    kind_t k;
    k = K_EOF;
    case (b)
      "+": k = K_PLUS;
      "-": k = K_MINUS;
      "/": k = K_SLASH;
      "%": k = K_PERCENT;
      "!": k = K_BANG;
      "~": k = K_TILDE;
      "&": k = K_AMP;
      "^": k = K_CARET;
      "|": k = K_PIPE;
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      ";": k = K_SEMI;
      ".": k = K_DOT;
      default: k = K_EOF;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: src/st_if.sv
// ----------------------------------------------------------------------------
// st_in_if / st_out_if: valid-ready channels of the source tokenizer
// Source bytes come in on st_in_if, tokens leave on st_out_if.
// ----------------------------------------------------------------------------
`default_nettype none

interface st_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] source_byte;

  modport source (output valid, action, source_byte, input ready);
  modport sink (input valid, action, source_byte, output ready);
endinterface

interface st_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [2:0]  error_code;
  logic [24:0] token_line;
  logic [24:0] start_column;
  logic [24:0] span_length;
  logic [23:0] text_offset;
  logic [24:0] content_length;
  logic [62:0] number_value;
  logic        last_of_run;

  modport source (output valid, token_kind, error_code, token_line, start_column,
                  span_length, text_offset, content_length, number_value, last_of_run,
                  input ready);
  modport sink (input valid, token_kind, error_code, token_line, start_column,
                span_length, text_offset, content_length, number_value, last_of_run,
                output ready);
endinterface

`default_nettype wire

// File: src/st_front.sv
// ----------------------------------------------------------------------------
// st_front: scanner front end
// Takes one beat per cycle while the queue has room, advances the scan state
// and pushes the zero, one or two tokens that the beat completes.
// ----------------------------------------------------------------------------
`default_nettype none

module st_front import st_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  st_in_if.sink        bytes,
  input  wire          room,
  output push_t        push
);

  typedef enum logic [3:0] {
    M_IDLE, M_COMMENT, M_IDENT, M_ZERO, M_DIGITS, M_OVERFLOW, M_BADDIGIT,
    M_STRING, M_ESCAPE, M_OP
  } mode_t;

  mode_t           scan_mode, mode_next;
  logic [PosW-1:0] byte_position, bp_next;
  logic [PosW-1:0] current_line, ln_next;
  logic [PosW-1:0] current_column, cl_next;
  logic [PosW-1:0] token_start_line, tsl_next;
  logic [PosW-1:0] token_start_column, tsc_next;
  logic [PosW-1:0] token_start_offset, tso_next;
  logic [ValW-1:0] literal_value, lv_next;
  base_t           number_base, nb_next;
  logic            digit_seen, ds_next;
  logic [47:0]     keyword_bytes, kw_next;
  kind_t           pending_operator, po_next;

  token_t          r0, r1;
  logic [1:0]      n;
  logic            accept;

  assign bytes.ready = room;
  assign accept      = bytes.valid && room;

  always_comb begin
    logic [7:0]      b;
    logic            handled;
    logic            prefix;
    logic            hv_ok;
    logic [3:0]      hv;
    logic            in_base;
    logic [ValW+3:0] prod;
    logic [PosW-1:0] span;
    logic [PosW-1:0] slen;
    logic [7:0]      opch;
    token_t          t;
    kind_t           ik;

    b         = bytes.source_byte;
    mode_next = scan_mode;
    bp_next   = byte_position;
    ln_next   = current_line;
    cl_next   = current_column;
    tsl_next  = token_start_line;
    tsc_next  = token_start_column;
    tso_next  = token_start_offset;
    lv_next   = literal_value;
    nb_next   = number_base;
    ds_next   = digit_seen;
    kw_next   = keyword_bytes;
    po_next   = pending_operator;
    r0        = '0;
    r1        = '0;
    n         = 2'd0;
    handled   = 1'b0;
    prefix    = 1'b0;
    hv_ok     = 1'b0;
    hv        = 4'd0;
    in_base   = 1'b0;
    prod      = '0;
    slen      = '0;
    t         = '0;
    ik        = K_IDENT;
    opch      = (pending_operator == K_STAR) ? "*" :
                (pending_operator == K_LT) ? "<" : ">";
    span      = byte_position - token_start_offset;

    // Identifier or keyword token, as seen before the current byte.
    if (span == 25'd2 && keyword_bytes == 48'h666E) ik = K_FN;
    else if (span == 25'd4 && keyword_bytes == 48'h6C696E6B) ik = K_LINK;
    else if (span == 25'd4 && keyword_bytes == 48'h6D61696E) ik = K_MAIN;
    else if (span == 25'd6 && keyword_bytes == 48'h72657475726E) ik = K_RETURN;

    if (bytes.action) begin
      // End of source: flush the token in progress, then end-of-file.
      t.line = token_start_line;
      t.col  = token_start_column;
      t.span = span;
      case (scan_mode)
        M_IDENT: begin
          t.kind = ik;
          t.toff = (token_start_offset > 25'(OfsMax)) ? OfsMax
                                                        : token_start_offset[OfsW-1:0];
          t.tlen = span;
        end
        M_ZERO:     t.kind = K_INT;
        M_DIGITS: begin
          if (digit_seen) begin
            t.kind  = K_INT;
            t.value = literal_value;
          end else begin
            t.kind = K_ERROR;
            t.err  = E_NODIG;
          end
        end
        M_OVERFLOW: begin t.kind = K_ERROR; t.err = E_OVF;    end
        M_BADDIGIT: begin t.kind = K_ERROR; t.err = E_BADDIG; end
        M_STRING:   begin t.kind = K_ERROR; t.err = E_UNSTR;  end
        M_ESCAPE:   begin t.kind = K_ERROR; t.err = E_UNESC;  end
        M_OP:       t.kind = pending_operator;
        default:    t.kind = K_EOF;
      endcase
      if (scan_mode != M_IDLE && scan_mode != M_COMMENT) begin
        r0 = t;
        n  = 2'd1;
      end
      mode_next = M_IDLE;
      tsl_next  = current_line;
      tsc_next  = current_column;
      tso_next  = byte_position;
      t         = '0;
      t.kind    = K_EOF;
      t.line    = current_line;
      t.col     = current_column;
      if (n == 2'd0) r0 = t;
      else r1 = t;
      n = n + 2'd1;
    end else begin
      t      = '0;
      t.line = token_start_line;
      t.col  = token_start_column;
      t.span = span;

      prefix = (b == "x" || b == "X" || b == "b" || b == "B" || b == "o" || b == "O");
      if (is_digit(b)) begin
        hv_ok = 1'b1; hv = 4'(b - "0");
      end else if (b >= "a" && b <= "f") begin
        hv_ok = 1'b1; hv = 4'(b - "a" + 8'd10);
      end else if (b >= "A" && b <= "F") begin
        hv_ok = 1'b1; hv = 4'(b - "A" + 8'd10);
      end

      if (scan_mode == M_ZERO) begin
        if (prefix) begin
          nb_next = (b == "x" || b == "X") ? B_HEX : (b == "b" || b == "B") ? B_BIN : B_OCT;
          lv_next = '0;
          ds_next = 1'b0;
          mode_next = M_DIGITS;
          handled = 1'b1;
        end else begin
          nb_next = B_DEC;
          lv_next = '0;
          ds_next = 1'b1;
          mode_next = M_DIGITS;
        end
      end

      case (nb_next)
        B_DEC: begin
          in_base = hv_ok && hv < 4'd10;
          prod = ({4'd0, lv_next} << 3) + ({4'd0, lv_next} << 1);
        end
        B_HEX: begin in_base = hv_ok;              prod = {4'd0, lv_next} << 4; end
        B_BIN: begin in_base = hv_ok && hv < 4'd2; prod = {4'd0, lv_next} << 1; end
        default: begin
          in_base = hv_ok && hv < 4'd8;
          prod = {4'd0, lv_next} << 3;
        end
      endcase
      prod = prod + {63'd0, hv};

      case (scan_mode)
        M_COMMENT: begin
          if (b != 8'h0A) handled = 1'b1;
          else mode_next = M_IDLE;
        end
        M_IDENT: begin
          if (is_word(b)) begin
            kw_next = {keyword_bytes[39:0], b};
            handled = 1'b1;
          end else begin
            t.kind = ik;
            t.toff = (token_start_offset > 25'(OfsMax)) ? OfsMax
                                                          : token_start_offset[OfsW-1:0];
            t.tlen = span;
            r0 = t; n = 2'd1;
            mode_next = M_IDLE;
          end
        end
        M_ZERO, M_DIGITS: begin
          if (!handled) begin
            if (in_base) begin
              handled = 1'b1;
              if (prod > {4'd0, IntMax}) mode_next = M_OVERFLOW;
              else begin
                lv_next = prod[ValW-1:0];
                ds_next = 1'b1;
              end
            end else if (!ds_next) begin
              t.kind = K_ERROR; t.err = E_NODIG;
              r0 = t; n = 2'd1;
              mode_next = M_IDLE;
            end else if (is_word(b)) begin
              mode_next = M_BADDIGIT;
              handled = 1'b1;
            end else begin
              t.kind = K_INT; t.value = lv_next;
              r0 = t; n = 2'd1;
              mode_next = M_IDLE;
            end
          end
        end
        M_OVERFLOW: begin
          if (is_alpha(b) || is_digit(b)) handled = 1'b1;
          else begin
            t.kind = K_ERROR; t.err = E_OVF;
            r0 = t; n = 2'd1;
            mode_next = M_IDLE;
          end
        end
        M_BADDIGIT: begin
          if (is_word(b)) handled = 1'b1;
          else begin
            t.kind = K_ERROR; t.err = E_BADDIG;
            r0 = t; n = 2'd1;
            mode_next = M_IDLE;
          end
        end
        M_STRING: begin
          if (b == "\"") begin
            slen = (span != '0) ? span - 25'd1 : '0;
            handled = 1'b1;
            t.kind = K_STRING;
            t.span = ((byte_position < PosCap) ? byte_position + 25'd1 : byte_position)
                     - token_start_offset;
            t.toff = (token_start_offset >= 25'(OfsMax)) ? OfsMax
                                                           : token_start_offset[OfsW-1:0] + 24'd1;
            t.tlen = slen;
            r0 = t; n = 2'd1;
            mode_next = M_IDLE;
          end else if (b == 8'h0A || b == 8'h00) begin
            t.kind = K_ERROR; t.err = E_UNSTR;
            r0 = t; n = 2'd1;
            mode_next = M_IDLE;
          end else begin
            if (b == "\\") mode_next = M_ESCAPE;
            handled = 1'b1;
          end
        end
        M_ESCAPE: begin
          if (b == 8'h0A || b == 8'h00) begin
            t.kind = K_ERROR; t.err = E_UNESC;
            r0 = t; n = 2'd1;
            mode_next = M_IDLE;
          end else begin
            mode_next = M_STRING;
            handled = 1'b1;
          end
        end
        M_OP: begin
          handled = (b == opch);
          t.kind = handled ? kind_t'(pending_operator - 5'd1) : pending_operator;
          // The paired byte counts towards the span unless the counter is full.
          if (handled) begin
            t.span = ((byte_position < PosCap) ? byte_position + 25'd1 : byte_position)
                     - token_start_offset;
          end
          r0 = t; n = 2'd1;
          mode_next = M_IDLE;
        end
        default: ;
      endcase

      if (!handled) begin
        // The byte starts a new token from the idle state.
        tsl_next  = current_line;
        tsc_next  = current_column;
        tso_next  = byte_position;
        mode_next = M_IDLE;
        t         = '0;
        t.line    = current_line;
        t.col     = current_column;
        t.span    = 25'd1;
        if (is_space(b)) begin
          mode_next = M_IDLE;
        end else if (b == "#") begin
          mode_next = M_COMMENT;
        end else if (is_alpha(b) || b == "_") begin
          mode_next = M_IDENT;
          kw_next = {40'd0, b};
        end else if (b == "0") begin
          mode_next = M_ZERO;
        end else if (is_digit(b)) begin
          mode_next = M_DIGITS;
          nb_next = B_DEC;
          lv_next = {59'd0, 4'(b - "0")};
          ds_next = 1'b1;
        end else if (b == "\"") begin
          mode_next = M_STRING;
        end else if (b == "*" || b == "<" || b == ">") begin
          mode_next = M_OP;
          po_next = (b == "*") ? K_STAR : (b == "<") ? K_LT : K_GT;
        end else begin
          if (op_kind(b) != K_EOF) t.kind = op_kind(b);
          else begin
            t.kind = K_ERROR; t.err = E_BADCHAR;
          end
          if (n == 2'd0) r0 = t;
          else r1 = t;
          n = n + 2'd1;
        end
      end

      // Every beat that is not an end of source consumes its byte once.
      if (byte_position < PosCap) bp_next = byte_position + 25'd1;
      if (b == 8'h0A) begin
        if (current_line < LcCap) ln_next = current_line + 25'd1;
        cl_next = 25'd1;
      end else if (current_column < LcCap) begin
        cl_next = current_column + 25'd1;
      end
    end

    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;
  end

  assign push.count  = accept ? n : 2'd0;
  assign push.first  = r0;
  assign push.second = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode          <= M_IDLE;
      byte_position      <= '0;
      current_line       <= 25'd1;
      current_column     <= 25'd1;
      token_start_line   <= 25'd1;
      token_start_column <= 25'd1;
      token_start_offset <= '0;
      literal_value      <= '0;
      number_base        <= B_DEC;
      digit_seen         <= 1'b0;
      keyword_bytes      <= '0;
      pending_operator   <= K_EOF;
    end else if (accept) begin
      scan_mode          <= mode_next;
      byte_position      <= bp_next;
      current_line       <= ln_next;
      current_column     <= cl_next;
      token_start_line   <= tsl_next;
      token_start_column <= tsc_next;
      token_start_offset <= tso_next;
      literal_value      <= lv_next;
      number_base        <= nb_next;
      digit_seen         <= ds_next;
      keyword_bytes      <= kw_next;
      pending_operator   <= po_next;
    end
  end

endmodule

`default_nettype wire

// File: src/st_queue.sv
// ----------------------------------------------------------------------------
// st_queue: token queue between the scanner and the output stage
// Takes up to two tokens a cycle and gives out one.
// ----------------------------------------------------------------------------
`default_nettype none

module st_queue import st_pkg::*; (
  input  wire    clk,
  input  wire    rst,
  input  push_t  push,
  input  wire    pop,
  output token_t head,
  output logic   not_empty,
  output logic   room
);

  token_t         entries [QDepth];
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic [QAw:0]   fill;
  logic [QAw-1:0] wr_ptr_plus;

  assign wr_ptr_plus = wr_ptr + QAw'(1);
  assign head        = entries[rd_ptr];
  assign not_empty   = fill != '0;
  assign room        = fill <= (QAw+1)'(QDepth - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) entries[wr_ptr] <= push.first;
    if (push.count == 2'd2) entries[wr_ptr_plus] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAw'(push.count);
      if (pop) rd_ptr <= rd_ptr + QAw'(1);
      fill <= fill + (QAw+1)'(push.count) - (QAw+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// File: src/st_back.sv
// ----------------------------------------------------------------------------
// st_back: token output stage
// Moves the queue head into the output register whenever that register is
// empty or its beat is being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module st_back import st_pkg::*; (
  input  wire     clk,
  input  wire     rst,
  input  token_t  head,
  input  wire     not_empty,
  output logic    pop,
  st_out_if.source tokens
);

  token_t hold;
  logic   valid;

  assign pop = not_empty && (!valid || tokens.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || tokens.ready) begin
      valid <= not_empty;
    end
    if (pop) hold <= head;
  end

  assign tokens.valid          = valid;
  assign tokens.token_kind     = hold.kind;
  assign tokens.error_code     = hold.err;
  assign tokens.token_line     = hold.line;
  assign tokens.start_column   = hold.col;
  assign tokens.span_length    = hold.span;
  assign tokens.text_offset    = hold.toff;
  assign tokens.content_length = hold.tlen;
  assign tokens.number_value   = hold.value;
  assign tokens.last_of_run    = hold.last;

endmodule

`default_nettype wire

// File: src/source_tokenizer.sv
// ----------------------------------------------------------------------------
// source_tokenizer: streaming tokenizer for a small language
// Scanner front end, token queue and registered output stage.
// ----------------------------------------------------------------------------
// Throughput: one source beat per cycle while the queue has room; tokens leave
// at one per cycle while the consumer is ready. A completed token is written
// into the queue and then moved into the output register.
// A beat that completes two tokens is absorbed by the four-entry queue; input
// is held off only while fewer than two entries are free.
// Reset is synchronous and returns the scanner to idle at line 1, column 1.
`default_nettype none

module source_tokenizer import st_pkg::*; (
  input  wire      clk,
  input  wire      rst,
  st_in_if.sink    bytes,
  st_out_if.source tokens
);

  // Tokens and their count travel from the scanner to the queue as a struct.
  push_t  push;
  token_t head;
  logic   room;
  logic   not_empty;
  logic   pop;

  // The front end does the whole scan step for a beat combinationally, so a new
  // byte can follow every cycle that the queue has room, also while tokens are queued.
  st_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .room  (room),
    .push  (push)
  );

  // The queue decouples the scanner from downstream stalls.
  st_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .room      (room)
  );

  // The output register holds a finished token until the consumer takes it.
  st_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .tokens    (tokens)
  );

endmodule

`default_nettype wire

// File: tb/sv/token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_checker: scoreboard of the source tokenizer
// Watches both channels, predicts the tokens caused by every accepted source
// beat and compares each accepted token, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module token_checker import st_pkg::*; (
  input  wire  clk,
  input  wire  rst,
  st_in_if     bytes,
  st_out_if    tokens,
  output int   fail_count,
  output int   pending
);

  typedef enum logic [3:0] {
    S_IDLE, S_COMMENT, S_IDENT, S_ZERO, S_DIGITS, S_OVERFLOW, S_BADDIGIT,
    S_STRING, S_ESCAPE, S_OP
  } scan_t;

  localparam logic [63:0] Int64Max = 64'h7FFF_FFFF_FFFF_FFFF;

  scan_t           mode;
  logic [PosW-1:0] pos, line, col, tok_line, tok_col, tok_ofs;
  logic [63:0]     lit;
  base_t           radix_code;
  logic            digit_seen;
  logic [47:0]     word_bytes;
  logic [7:0]      pend_op;

  token_t run_tokens[$];
  token_t expected_tokens[$];

  function automatic void clear_scanner();
    mode = S_IDLE;
    pos = '0;
    line = 1;
    col = 1;
    tok_line = 1;
    tok_col = 1;
    tok_ofs = '0;
    lit = '0;
    radix_code = B_DEC;
    digit_seen = 1'b0;
    word_bytes = '0;
    pend_op = '0;
  endfunction

  function automatic logic [PosW-1:0] span_so_far();
    return (pos >= tok_ofs) ? pos - tok_ofs : '0;
  endfunction

  function automatic void advance(logic [7:0] b);
    if (pos < PosCap) pos = pos + 1;
    if (b == 8'h0A) begin
      if (line < LcCap) line = line + 1;
      col = 1;
    end else if (col < LcCap) begin
      col = col + 1;
    end
  endfunction

  // Only two tokens can come out of one beat; further ones are dropped.
  function automatic void record(kind_t k, err_t e, logic [PosW-1:0] sp,
                                 logic [PosW-1:0] ofs, logic [PosW-1:0] len,
                                 logic [63:0] v);
    token_t t;
    if (run_tokens.size() >= 2) return;
    t.kind  = k;
    t.err   = e;
    t.line  = tok_line;
    t.col   = tok_col;
    t.span  = sp;
    t.toff  = (ofs > PosW'(OfsMax)) ? OfsMax : ofs[OfsW-1:0];
    t.tlen  = len;
    t.value = v[ValW-1:0];
    t.last  = 1'b0;
    run_tokens.push_back(t);
  endfunction

  function automatic void record_error(err_t e);
    record(K_ERROR, e, span_so_far(), '0, '0, '0);
  endfunction

  function automatic void record_word();
    logic [PosW-1:0] len;
    kind_t k;
    len = span_so_far();
    k = K_IDENT;
    if (len == 2 && word_bytes == 48'h666E) k = K_FN;
    else if (len == 4 && word_bytes == 48'h6C696E6B) k = K_LINK;
    else if (len == 4 && word_bytes == 48'h6D61696E) k = K_MAIN;
    else if (len == 6 && word_bytes == 48'h72657475726E) k = K_RETURN;
    record(k, E_NONE, len, tok_ofs, len, '0);
  endfunction

  function automatic void record_single_op();
    kind_t k;
    k = (pend_op == "*") ? K_STAR : (pend_op == "<") ? K_LT : K_GT;
    record(k, E_NONE, span_so_far(), '0, '0, '0);
  endfunction

  function automatic int digit_value(logic [7:0] b);
    if (is_digit(b)) return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  // A byte seen from the idle state always begins something and is consumed.
  function automatic void begin_token(logic [7:0] b);
    kind_t k;
    tok_line = line;
    tok_col = col;
    tok_ofs = pos;
    advance(b);
    if (is_space(b)) return;
    if (b == "#") begin
      mode = S_COMMENT;
    end else if (is_alpha(b) || b == "_") begin
      mode = S_IDENT;
      word_bytes = {40'd0, b};
    end else if (b == "0") begin
      mode = S_ZERO;
    end else if (is_digit(b)) begin
      mode = S_DIGITS;
      radix_code = B_DEC;
      lit = 64'(b - "0");
      digit_seen = 1'b1;
    end else if (b == 8'h22) begin
      mode = S_STRING;
    end else if (b == "*" || b == "<" || b == ">") begin
      mode = S_OP;
      pend_op = b;
    end else begin
      k = op_kind(b);
      if (k != K_EOF) record(k, E_NONE, 1, '0, '0, '0);
      else record(K_ERROR, E_BADCHAR, 1, '0, '0, '0);
    end
  endfunction

  // Returns 1 when the token in progress takes the byte.
  function automatic logic extend_token(logic [7:0] b);
    logic [63:0] radix, d;
    logic [PosW-1:0] len;
    int hv;
    // A lone zero followed by no prefix letter is a decimal literal so far.
    if (mode == S_ZERO && !(b == "x" || b == "X" || b == "b" || b == "B" ||
                            b == "o" || b == "O")) begin
      radix_code = B_DEC;
      lit = '0;
      digit_seen = 1'b1;
      mode = S_DIGITS;
    end
    case (mode)
      S_COMMENT: begin
        if (b != 8'h0A) begin
          advance(b);
          return 1'b1;
        end
      end
      S_IDENT: begin
        if (is_word(b)) begin
          word_bytes = {word_bytes[39:0], b};
          advance(b);
          return 1'b1;
        end
        record_word();
      end
      S_ZERO: begin
        radix_code = (b == "x" || b == "X") ? B_HEX : (b == "b" || b == "B") ? B_BIN : B_OCT;
        lit = '0;
        digit_seen = 1'b0;
        mode = S_DIGITS;
        advance(b);
        return 1'b1;
      end
      S_DIGITS: begin
        radix = (radix_code == B_HEX) ? 64'd16 : (radix_code == B_BIN) ? 64'd2 :
                (radix_code == B_OCT) ? 64'd8 : 64'd10;
        hv = digit_value(b);
        if (hv >= 0 && 64'(hv) < radix) begin
          d = 64'(hv);
          advance(b);
          if (lit > (Int64Max - d) / radix) begin
            mode = S_OVERFLOW;
          end else begin
            lit = lit * radix + d;
            digit_seen = 1'b1;
          end
          return 1'b1;
        end
        if (!digit_seen) begin
          record_error(E_NODIG);
        end else if (is_word(b)) begin
          mode = S_BADDIGIT;
          advance(b);
          return 1'b1;
        end else begin
          record(K_INT, E_NONE, span_so_far(), '0, '0, lit);
        end
      end
      S_OVERFLOW: begin
        if (is_alpha(b) || is_digit(b)) begin
          advance(b);
          return 1'b1;
        end
        record_error(E_OVF);
      end
      S_BADDIGIT: begin
        if (is_word(b)) begin
          advance(b);
          return 1'b1;
        end
        record_error(E_BADDIG);
      end
      S_STRING: begin
        if (b == 8'h22) begin
          len = span_so_far();
          len = (len > 0) ? len - 1 : '0;
          advance(b);
          record(K_STRING, E_NONE, span_so_far(), tok_ofs + 1, len, '0);
          mode = S_IDLE;
          return 1'b1;
        end
        if (b == 8'h0A || b == 8'h00) begin
          record_error(E_UNSTR);
        end else begin
          if (b == 8'h5C) mode = S_ESCAPE;
          advance(b);
          return 1'b1;
        end
      end
      S_ESCAPE: begin
        if (b == 8'h0A || b == 8'h00) begin
          record_error(E_UNESC);
        end else begin
          mode = S_STRING;
          advance(b);
          return 1'b1;
        end
      end
      S_OP: begin
        if (b == pend_op) begin
          advance(b);
          record((pend_op == "*") ? K_POW : (pend_op == "<") ? K_SHL : K_SHR,
                 E_NONE, span_so_far(), '0, '0, '0);
          mode = S_IDLE;
          return 1'b1;
        end
        record_single_op();
      end
      default: ;
    endcase
    mode = S_IDLE;
    return 1'b0;
  endfunction

  function automatic void end_of_source();
    case (mode)
      S_IDENT:    record_word();
      S_ZERO:     record(K_INT, E_NONE, span_so_far(), '0, '0, '0);
      S_DIGITS: begin
        if (!digit_seen) record_error(E_NODIG);
        else record(K_INT, E_NONE, span_so_far(), '0, '0, lit);
      end
      S_OVERFLOW: record_error(E_OVF);
      S_BADDIGIT: record_error(E_BADDIG);
      S_STRING:   record_error(E_UNSTR);
      S_ESCAPE:   record_error(E_UNESC);
      S_OP:       record_single_op();
      default: ;
    endcase
    mode = S_IDLE;
    tok_line = line;
    tok_col = col;
    tok_ofs = pos;
    record(K_EOF, E_NONE, '0, '0, '0, '0);
  endfunction

  function automatic void predict_beat(logic act, logic [7:0] b);
    logic taken;
    run_tokens.delete();
    if (act) begin
      end_of_source();
    end else if (mode == S_IDLE) begin
      begin_token(b);
    end else begin
      taken = extend_token(b);
      if (!taken) begin_token(b);
    end
    if (run_tokens.size() > 0) run_tokens[run_tokens.size() - 1].last = 1'b1;
    foreach (run_tokens[i]) expected_tokens.push_back(run_tokens[i]);
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    clear_scanner();
  end

  // Sampled at the rising edge, before the block updates its registers.
  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      clear_scanner();
      expected_tokens.delete();
    end else begin
      if (tokens.valid && tokens.ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: token of kind %0d with nothing expected", $realtime,
                   tokens.token_kind);
          fail_count++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("token_kind", want.kind, tokens.token_kind);
          check_field("error_code", want.err, tokens.error_code);
          check_field("token_line", want.line, tokens.token_line);
          check_field("start_column", want.col, tokens.start_column);
          check_field("span_length", want.span, tokens.span_length);
          check_field("text_offset", want.toff, tokens.text_offset);
          check_field("content_length", want.tlen, tokens.content_length);
          check_field("number_value", want.value, tokens.number_value);
          check_field("last_of_run", want.last, tokens.last_of_run);
        end
      end
      if (bytes.valid && bytes.ready) predict_beat(bytes.action, bytes.source_byte);
    end
    pending = expected_tokens.size();
  end

endmodule

// File: tb/sv/tb_source_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_source_tokenizer: testbench of the source tokenizer
// Feeds a directed source text and then random token fragments, noise and
// end-of-source beats, with random gaps and output stalls; token_checker
// predicts and compares every token.
// ----------------------------------------------------------------------------
module tb_source_tokenizer;
  import st_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;

  // Each queued beat is {action, byte}.
  logic [8:0] beat_queue[$];
  int         sent;
  logic       steady_in;
  logic       steady_out;

  st_in_if  bytes_ch ();
  st_out_if tokens_ch ();

  source_tokenizer u_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_ch),
    .tokens (tokens_ch)
  );

  token_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .bytes      (bytes_ch),
    .tokens     (tokens_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Queues the bytes of a piece of source text.
  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) beat_queue.push_back({1'b0, s[i]});
  endtask

  task automatic add_byte(logic [7:0] b);
    beat_queue.push_back({1'b0, b});
  endtask

  task automatic add_end();
    beat_queue.push_back({1'b1, 8'($urandom)});
  endtask

  // A character drawn from the given set.
  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // One random fragment of source. Most are well-formed tokens with random
  // content; the rest are broken literals, raw noise and end-of-source beats.
  task automatic add_fragment();
    string letters, digits;
    int n;
    letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    digits = "0123456789";
    case ($urandom_range(0, 11))
      0: begin
        case ($urandom_range(0, 3))
          0: add_text("fn");
          1: add_text("link");
          2: add_text("main");
          default: add_text("return");
        endcase
      end
      1: begin
        add_byte(pick(letters));
        n = $urandom_range(0, 8);
        repeat (n) add_byte(pick({letters, digits}));
      end
      2: begin
        n = $urandom_range(1, 21);
        repeat (n) add_byte(pick(digits));
      end
      3: begin
        add_byte("0");
        case ($urandom_range(0, 2))
          0: begin
            add_byte(pick("xX"));
            n = $urandom_range(0, 17);
            repeat (n) add_byte(pick("0123456789abcdefABCDEF"));
          end
          1: begin
            add_byte(pick("bB"));
            n = $urandom_range(0, 66);
            repeat (n) add_byte(pick("01"));
          end
          default: begin
            add_byte(pick("oO"));
            n = $urandom_range(0, 23);
            repeat (n) add_byte(pick("01234567"));
          end
        endcase
        if ($urandom_range(0, 3) == 0) add_byte(pick({letters, digits}));
      end
      4: begin
        add_byte(8'h22);
        n = $urandom_range(0, 10);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0) add_byte(8'h5C);
          add_byte(8'($urandom_range(32, 126)));
        end
        case ($urandom_range(0, 5))
          0: add_byte(8'h0A);
          1: add_byte(8'h00);
          2: begin
            add_byte(8'h5C);
            case ($urandom_range(0, 2))
              0: add_byte(8'h0A);
              1: add_byte(8'h00);
              default: add_byte(8'h22);
            endcase
          end
          default: add_byte(8'h22);
        endcase
      end
      5, 6: begin
        n = $urandom_range(1, 3);
        repeat (n) add_byte(pick("+-*/%!~<>&^|(){};.**<<>>"));
      end
      7: begin
        add_byte("#");
        n = $urandom_range(0, 12);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
        add_byte(8'h0A);
      end
      8, 9: add_byte(8'($urandom_range(0, 255)));
      10: add_end();
      default: add_byte(pick(" \t\n\013\014\015"));
    endcase
    if ($urandom_range(0, 1) == 0) add_byte(pick(" \n\t"));
  endtask

  // Drives one beat at the falling edge and holds it until it is taken.
  // The ready line is registered in the block, so a look at it halfway
  // through the low phase is what the next rising edge will see.
  task automatic send_beat(logic [8:0] item);
    int gap;
    logic rdy;
    if ($urandom_range(0, 40) == 0) steady_in = ~steady_in;
    gap = steady_in ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      bytes_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    bytes_ch.valid       = 1'b1;
    bytes_ch.action      = item[8];
    bytes_ch.source_byte = item[7:0];
    do begin
      #0.5;
      rdy = bytes_ch.ready;
      @(posedge clk);
      @(negedge clk);
    end while (!rdy);
    sent++;
  endtask

  task automatic send_all();
    while (beat_queue.size() > 0) send_beat(beat_queue.pop_front());
  endtask

  // Sink side: a random stall before each token, with stretches of none.
  initial begin
    int stall;
    logic vld;
    tokens_ch.ready = 1'b0;
    steady_out = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 40) == 0) steady_out = ~steady_out;
      stall = steady_out ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        tokens_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      tokens_ch.ready = 1'b1;
      do begin
        #0.5;
        vld = tokens_ch.valid;
        @(posedge clk);
        @(negedge clk);
      end while (!vld);
    end
  end

  initial begin
    bytes_ch.valid       = 1'b0;
    bytes_ch.action      = 1'b0;
    bytes_ch.source_byte = 8'h00;
    steady_in = 1'b0;
    sent = 0;
    rst = 1'b1;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed text: every keyword, every base, the int64 limit and one past
    // it, a prefix with no digits, a bad digit, escapes, strings cut short by
    // a newline or a NUL, paired and single operators, a bad character, a
    // comment and a flush of an unfinished identifier, operator, string and prefix.
    add_text("fn link main return _x9 0 0x7fffFFFFffffffff 0b101 0o17 ");
    add_text("9223372036854775807 9223372036854775808z_ 0x; 12ab ");
    add_text("\"a\\\"b\" \"cut\n\"esc\\\n");
    add_byte(8'h22);
    add_byte(8'h00);
    add_text("\"q\\");
    add_byte(8'h00);
    add_byte(8'h00);
    add_text("** << >> * < > +-/%!~&^|(){};. @# note\n");
    add_byte(8'hFF);
    add_text("ret");
    add_end();
    add_text("<");
    add_end();
    add_text("\"open");
    add_end();
    add_text("0x");
    add_end();
    add_end();
    send_all();

    for (int i = 0; i < 40; i++) begin
      add_fragment();
      send_all();
      // Let the pipe drain completely once, part way through.
      if (i == 20) begin
        bytes_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (5) @(negedge clk);
      end
    end
    add_end();
    send_all();
    bytes_ch.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
